@@ rtl/iar_pkg.sv @@
// Shared types and constants for the integer to ASCII radix converter.
package iar_pkg;

   // Number base codes held in the configuration register.
   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_DEC = 2'd2,
      RADIX_HEX = 2'd3
   } radix_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MUL   = 6'b000010,
      S_STEP  = 6'b000100,
      S_SIGN  = 6'b001000,
      S_READ  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;        // capture a new input beat
      logic mul;         // register the reciprocal product
      logic step;        // produce one digit and replace the value by its quotient
      logic read;        // fetch the next digit, most significant first
      logic show_minus;  // the output shows the minus sign
   } cmd_type;

   typedef struct packed {
      logic is_dec;
      logic negative;
      logic quot_zero;
      logic idx_zero;
   } status_type;

   localparam int         DATA_WIDTH  = 32;
   localparam int         IDX_WIDTH   = 6;
   localparam int         ADDR_WIDTH  = 5;
   localparam int         STORE_DEPTH = 32;
   // ceil(2^35 / 10): the quotient of a 32-bit value by ten is (v * DEC_RECIP) >> 35.
   localparam logic [31:0] DEC_RECIP  = 32'hCCCC_CCCD;
   localparam int         DEC_SHIFT   = 35;
   localparam logic [6:0] CHAR_ZERO   = 7'd48;
   localparam logic [6:0] CHAR_ALPHA  = 7'd55;
   localparam logic [6:0] CHAR_MINUS  = 7'd45;
   localparam logic [3:0] MAX_DEC_DIGIT = 4'd9;

endpackage

@@ rtl/integer_to_ascii_radix.sv @@
// Top level of the integer to ASCII radix converter.
//
// Each accepted beat carries one integer, which leaves as a run of ASCII characters, most
// significant digit first, with the last one flagged; a negative signed value is led by
// '-'. The base (2, 8, 10, 16) comes from the csr register and must only change while the
// block is idle. One number is handled at a time: the value is divided down one digit per
// pass into a 32-entry digit memory; for decimal, each digit step follows a registered
// reciprocal multiply. Each character then goes through a registered memory read and then
// onto the output, where it waits out any output stall.
module integer_to_ascii_radix import iar_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value_bits,
   input  logic        req_is_signed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_ascii_char,
   output logic        rsp_last_char
);

   cmd_type    cmd;
   status_type status;

   iar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   iar_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_value_bits (req_value_bits),
      .req_is_signed  (req_is_signed),
      .cmd            (cmd),
      .status         (status),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

@@ rtl/iar_ctrl.sv @@
// Sequencer for the integer to ASCII radix converter.
module iar_ctrl import iar_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_SIGN) || (state_ff == S_OUT);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.show_minus = (state_ff == S_SIGN);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // Power-of-two bases need no product and move straight on.
            if (status.is_dec) begin
               cmd.mul  = 1'b1;
               state_in = S_STEP;
            end else begin
               cmd.step = 1'b1;
               if (status.quot_zero) begin
                  state_in = status.negative ? S_SIGN : S_READ;
               end
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (status.quot_zero) begin
               state_in = status.negative ? S_SIGN : S_READ;
            end else begin
               state_in = S_MUL;
            end
         end
         S_SIGN: begin
            if (!rsp_stall) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = status.idx_zero ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/iar_datapath.sv @@
// Value register, digit extraction, digit store and output character for the converter.
module iar_datapath import iar_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic [31:0] req_value_bits,
   input  logic        req_is_signed,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [6:0]  rsp_ascii_char,
   output logic        rsp_last_char
);

   // Bits of the input word that take part; above 32 the missing bits are zero.
   localparam int SIG_WIDTH = (VALUE_WIDTH < DATA_WIDTH) ? VALUE_WIDTH : DATA_WIDTH;
   localparam logic [DATA_WIDTH-1:0] VALUE_MASK =
      DATA_WIDTH'((64'd1 << SIG_WIDTH) - 64'd1);
   localparam bit SIGN_IN_RANGE = (VALUE_WIDTH <= DATA_WIDTH);

   radix_type              radix_ff;
   logic [DATA_WIDTH-1:0]  rem_ff, rem_in;
   logic                   neg_ff, neg_in;
   logic [2*DATA_WIDTH-1:0] prod_ff;
   logic [IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic [3:0]             rd_ff;
   logic [3:0]             digit_store [STORE_DEPTH];

   logic [DATA_WIDTH-1:0]  masked;
   logic                   sign_bit;
   logic [DATA_WIDTH-1:0]  quot;
   logic [DATA_WIDTH-1:0]  quot_times_ten;
   logic [3:0]             digit;
   logic [IDX_WIDTH-1:0]   idx_dec;
   logic [6:0]             digit_char;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_DEC;
      end else if (csr_wr_en) begin
         radix_ff <= radix_type'(csr_wr_data);
      end
   end

   assign masked   = req_value_bits & VALUE_MASK;
   assign sign_bit = SIGN_IN_RANGE ? req_value_bits[SIG_WIDTH-1] : 1'b0;
   assign idx_dec  = idx_ff - IDX_WIDTH'(1);
   assign quot_times_ten = (quot << 3) + (quot << 1);

   always_comb begin
      quot  = '0;
      digit = '0;
      case (radix_ff)
         RADIX_BIN: begin
            quot  = rem_ff >> 1;
            digit = {3'b000, rem_ff[0]};
         end
         RADIX_OCT: begin
            quot  = rem_ff >> 3;
            digit = {1'b0, rem_ff[2:0]};
         end
         RADIX_HEX: begin
            quot  = rem_ff >> 4;
            digit = rem_ff[3:0];
         end
         RADIX_DEC: begin
            quot  = DATA_WIDTH'(prod_ff >> DEC_SHIFT);
            digit = 4'(rem_ff - quot_times_ten);
         end
         default: begin
            quot  = '0;
            digit = '0;
         end
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      neg_in = neg_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         neg_in = req_is_signed && sign_bit;
         rem_in = neg_in ? ((~masked + DATA_WIDTH'(1)) & VALUE_MASK) : masked;
         idx_in = '0;
      end else if (cmd.step) begin
         rem_in = quot;
         idx_in = idx_ff + IDX_WIDTH'(1);
      end else if (cmd.read) begin
         idx_in = idx_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rem_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      if (cmd.mul) begin
         prod_ff <= (2*DATA_WIDTH)'(rem_ff) * (2*DATA_WIDTH)'(DEC_RECIP);
      end
   end

   // Digits go in least significant first and come out in reverse order.
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         digit_store[idx_ff[ADDR_WIDTH-1:0]] <= digit;
      end
      if (cmd.read) begin
         rd_ff <= digit_store[idx_dec[ADDR_WIDTH-1:0]];
      end
   end

   assign digit_char = (rd_ff > MAX_DEC_DIGIT) ? (7'(rd_ff) + CHAR_ALPHA)
                                               : (7'(rd_ff) + CHAR_ZERO);

   assign rsp_ascii_char = cmd.show_minus ? CHAR_MINUS : digit_char;
   assign rsp_last_char  = !cmd.show_minus && (idx_ff == '0);

   assign status.is_dec    = (radix_ff == RADIX_DEC);
   assign status.negative  = neg_ff;
   assign status.quot_zero = (quot == '0);
   assign status.idx_zero  = (idx_ff == '0);

endmodule
